// ===== rtl/nfca_pkg.sv =====
package nfca_pkg;

  // Grid limits and field widths.
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int FIELD_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int DIST_W      = FIELD_W + 1;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED      = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    start_scan;
    logic    write_cell;
    logic    emit;
    status_t code;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic scan_done;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/nfca_ctrl.sv =====
module nfca_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  nfca_pkg::dp_stat_t   stat,
  output nfca_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  nfca_pkg::status_t code_r;
  nfca_pkg::status_t code_nxt;

  // Next state and the result code that goes with it.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.in_range) begin
          state_nxt = ST_SCAN;
        end else begin
          code_nxt  = nfca_pkg::STATUS_OUT_OF_RANGE;
          state_nxt = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          if (stat.found) begin
            code_nxt  = nfca_pkg::STATUS_GRANTED;
            state_nxt = ST_WRITE;
          end else begin
            code_nxt  = nfca_pkg::STATUS_FULL;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      code_r  <= nfca_pkg::STATUS_GRANTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Commands decoded from the current state.
  assign in_tready      = (state_r == ST_IDLE);
  assign cmd.load       = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.start_scan = (state_r == ST_CHECK) && stat.in_range;
  assign cmd.write_cell = (state_r == ST_WRITE);
  assign cmd.emit       = (state_r == ST_RESULT) && stat.out_free;
  assign cmd.code       = code_r;

endmodule

// ===== rtl/nfca_datapath.sv =====
module nfca_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [nfca_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [nfca_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  input  logic [nfca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nfca_pkg::FIELD_W-1:0]         cfg_data,
  input  nfca_pkg::ctrl_cmd_t                  cmd,
  output nfca_pkg::dp_stat_t                   stat
);

  localparam int FW = nfca_pkg::FIELD_W;
  localparam int RW = nfca_pkg::ROW_W;
  localparam int CW = nfca_pkg::COL_W;
  localparam int DW = nfca_pkg::DIST_W;
  localparam int NC = nfca_pkg::MAX_COLUMNS;
  localparam int NR = nfca_pkg::MAX_ROWS;

  // Configuration registers.
  logic [FW-1:0] row_count_r;
  logic [FW-1:0] column_count_r;

  // Request registers.
  logic [FW-1:0] wanted_row_r;
  logic [FW-1:0] wanted_column_r;

  // Occupancy memory, one word per row, with a valid bit per row.
  logic [NC-1:0] occ_mem [NR];
  logic [NR-1:0] row_valid_r;
  logic [NC-1:0] mem_q_r;
  logic          rd_ok_r;

  // Scan control.
  logic          scan_active_r;
  logic [RW-1:0] rd_row_r;
  logic [RW-1:0] ev_row_r;
  logic          ev_valid_r;

  // Best cell so far.
  logic          best_found_r;
  logic [RW-1:0] best_row_r;
  logic [CW-1:0] best_col_r;
  logic [DW-1:0] best_dist_r;
  logic [NC-1:0] best_word_r;

  // Output register.
  logic                          out_valid_r;
  logic [nfca_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [FW-1:0] rows_eff;
  logic [FW-1:0] cols_eff;
  logic          in_range;
  logic [RW-1:0] x_idx;
  logic [CW-1:0] y_idx;
  logic [NC-1:0] col_mask;
  logic [NC-1:0] row_word;
  logic [NC-1:0] free_bits;
  logic          left_found;
  logic          right_found;
  logic [CW-1:0] left_idx;
  logic [CW-1:0] right_idx;
  logic [CW-1:0] left_dist;
  logic [CW-1:0] right_dist;
  logic          row_hit;
  logic [CW-1:0] row_col;
  logic [CW-1:0] col_dist;
  logic [RW-1:0] row_dist;
  logic [DW-1:0] total_dist;
  logic          better;
  logic          last_read;
  logic          out_free;

  // Effective grid size, clamped to the physical grid.
  assign rows_eff = (row_count_r > FW'(NR)) ? FW'(NR) : row_count_r;
  assign cols_eff = (column_count_r > FW'(NC)) ? FW'(NC) : column_count_r;

  assign in_range = (wanted_row_r != '0) && (wanted_row_r <= rows_eff) &&
                    (wanted_column_r != '0) && (wanted_column_r <= cols_eff);

  assign x_idx = RW'(wanted_row_r - FW'(1));
  assign y_idx = CW'(wanted_column_r - FW'(1));

  assign last_read = ({1'b0, rd_row_r} == (rows_eff - FW'(1)));
  assign out_free  = !out_valid_r || out_tready;

  // Nearest free column of the row under evaluation.
  always_comb begin
    col_mask    = '0;
    left_found  = 1'b0;
    right_found = 1'b0;
    left_idx    = '0;
    right_idx   = '0;
    for (int j = 0; j < NC; j++) begin
      col_mask[j] = (FW'(j) < cols_eff);
    end
    row_word  = rd_ok_r ? mem_q_r : '0;
    free_bits = ~row_word & col_mask;
    // Highest free column at or left of the wanted one.
    for (int j = 0; j < NC; j++) begin
      if (free_bits[j] && (CW'(j) <= y_idx)) begin
        left_found = 1'b1;
        left_idx   = CW'(j);
      end
    end
    // Lowest free column at or right of the wanted one.
    for (int j = NC - 1; j >= 0; j--) begin
      if (free_bits[j] && (CW'(j) >= y_idx)) begin
        right_found = 1'b1;
        right_idx   = CW'(j);
      end
    end
    left_dist  = y_idx - left_idx;
    right_dist = right_idx - y_idx;
    row_hit    = left_found || right_found;
    // Equal distance goes to the smaller column.
    if (left_found && (!right_found || (left_dist <= right_dist))) begin
      row_col  = left_idx;
      col_dist = left_dist;
    end else begin
      row_col  = right_idx;
      col_dist = right_dist;
    end
    row_dist   = (ev_row_r >= x_idx) ? (ev_row_r - x_idx) : (x_idx - ev_row_r);
    total_dist = DW'(row_dist) + DW'(col_dist);
    better     = ev_valid_r && row_hit && (!best_found_r || (total_dist < best_dist_r));
  end

  // Occupancy memory: read during the scan, one write per grant.
  always_ff @(posedge clk) begin
    if (cmd.write_cell) begin
      occ_mem[best_row_r] <= best_word_r | (NC'(1) << best_col_r);
    end
    mem_q_r <= occ_mem[rd_row_r];
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= FW'(64);
      column_count_r <= FW'(64);
      row_valid_r    <= '0;
      scan_active_r  <= 1'b0;
      rd_row_r       <= '0;
      ev_valid_r     <= 1'b0;
      best_found_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          nfca_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_data;
          nfca_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.write_cell) begin
        row_valid_r[best_row_r] <= 1'b1;
      end
      // Row read pointer walks rows from the first to the last in use.
      if (cmd.start_scan) begin
        scan_active_r <= 1'b1;
        rd_row_r      <= '0;
        best_found_r  <= 1'b0;
      end else if (scan_active_r) begin
        rd_row_r <= rd_row_r + RW'(1);
        if (last_read) begin
          scan_active_r <= 1'b0;
        end
      end
      ev_valid_r <= scan_active_r && !cmd.start_scan;
      if (better) begin
        best_found_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wanted_row_r    <= in_tdata[FW-1:0];
      wanted_column_r <= in_tdata[2*FW-1:FW];
    end
    rd_ok_r  <= row_valid_r[rd_row_r];
    ev_row_r <= rd_row_r;
    if (better) begin
      best_row_r  <= ev_row_r;
      best_col_r  <= row_col;
      best_dist_r <= total_dist;
      best_word_r <= row_word;
    end
    if (cmd.emit) begin
      if (cmd.code == nfca_pkg::STATUS_GRANTED) begin
        out_data_r <= {cmd.code, FW'(best_col_r) + FW'(1), FW'(best_row_r) + FW'(1)};
      end else begin
        out_data_r <= {cmd.code, FW'(0), FW'(0)};
      end
    end
  end

  assign stat.in_range  = in_range;
  assign stat.scan_done = !scan_active_r && !ev_valid_r;
  assign stat.found     = best_found_r;
  assign stat.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/nearest_free_cell_allocator_top.sv =====
// A granted request goes through the scan of the rows in use (row_count clamped to 64) and a
// cell write before its result shows, a full grid through the scan only, and a request outside
// the grid skips the scan. One request is handled at a time; the scan reads one occupancy row
// per cycle from the row memory, and the next word is taken the cycle after emit.
// Reset (synchronous, rst_n low): all cells free, both counts back to 64, no result held.
module nearest_free_cell_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [6:0] wanted_row, [13:7] wanted_column, [15:14] zero
  input  logic [nfca_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [6:0] assigned_row, [13:7] assigned_column, [15:14] status
  output logic [nfca_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nfca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfca_pkg::FIELD_W-1:0]        cfg_data
);

  nfca_pkg::ctrl_cmd_t cmd;
  nfca_pkg::dp_stat_t  stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  nfca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfca_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
